### sv/sbc_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 block compression package
// Shared types, constants and the microcode table of the sequencer.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned ChainWords = 5;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned SelW       = 3;
  localparam int unsigned PcW        = 3;
  localparam int unsigned CntW       = 5;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ROUND,
    OP_ADD,
    OP_EMIT
  } op_e;

  // Round function choice.
  typedef enum logic [1:0] {
    FN_CH,
    FN_PAR,
    FN_MAJ
  } func_e;

  // Condition that ends a step.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_START,
    COND_COUNT,
    COND_OUT
  } cond_e;

  typedef struct packed {
    op_e              op;
    func_e            func;
    cond_e            cond;
    logic [CntW-1:0]  lim;
    logic [PcW-1:0]   nxt;
    logic [WordW-1:0] k;
  } ucode_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    op_e              op;
    func_e            func;
    logic [WordW-1:0] k;
    logic [SelW-1:0]  sel;
  } ctrl_t;

  localparam logic [PcW-1:0] PcIdle  = 3'd0;
  localparam logic [PcW-1:0] PcLoad  = 3'd1;
  localparam logic [PcW-1:0] PcRnd0  = 3'd2;
  localparam logic [PcW-1:0] PcRnd1  = 3'd3;
  localparam logic [PcW-1:0] PcRnd2  = 3'd4;
  localparam logic [PcW-1:0] PcRnd3  = 3'd5;
  localparam logic [PcW-1:0] PcAdd   = 3'd6;
  localparam logic [PcW-1:0] PcEmit  = 3'd7;

  localparam logic [CntW-1:0] RoundsPerPhase = 5'd19;
  localparam logic [CntW-1:0] LastEmit       = CntW'(ChainWords - 1);

  // The microprogram: wait, load, four phases of twenty rounds, add, emit.
  function automatic ucode_t sbc_ucode(input logic [PcW-1:0] pc);
    ucode_t uc;
    unique case (pc)
      PcIdle: uc = '{OP_NOP,   FN_CH,  COND_START, '0,             PcLoad, '0};
      PcLoad: uc = '{OP_LOAD,  FN_CH,  COND_NONE,  '0,             PcRnd0, '0};
      PcRnd0: uc = '{OP_ROUND, FN_CH,  COND_COUNT, RoundsPerPhase, PcRnd1, K0};
      PcRnd1: uc = '{OP_ROUND, FN_PAR, COND_COUNT, RoundsPerPhase, PcRnd2, K1};
      PcRnd2: uc = '{OP_ROUND, FN_MAJ, COND_COUNT, RoundsPerPhase, PcRnd3, K2};
      PcRnd3: uc = '{OP_ROUND, FN_PAR, COND_COUNT, RoundsPerPhase, PcAdd,  K3};
      PcAdd:  uc = '{OP_ADD,   FN_CH,  COND_NONE,  '0,             PcEmit, '0};
      PcEmit: uc = '{OP_EMIT,  FN_CH,  COND_OUT,   LastEmit,       PcIdle, '0};
    endcase
    return uc;
  endfunction

endpackage

### sv/sbc_seq.sv
// ----------------------------------------------------------------------------
// SHA-1 block compression sequencer
// Step counter, loop counter and microcode table lookup.
// ----------------------------------------------------------------------------
module sbc_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          out_ready_i,
  output sbc_pkg::ctrl_t ctrl_o
);
  import sbc_pkg::*;

  logic [PcW-1:0]  pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  ucode_t          uc;
  logic            done;
  logic            step;

  always_comb begin
    uc = sbc_ucode(pc_q);
    unique case (uc.cond)
      COND_NONE:  begin done = 1'b1;                          step = 1'b0;        end
      COND_START: begin done = start_i;                       step = 1'b0;        end
      COND_COUNT: begin done = (cnt_q == uc.lim);             step = 1'b1;        end
      COND_OUT:   begin done = out_ready_i && (cnt_q == uc.lim); step = out_ready_i; end
      default:    begin done = 1'b1;                          step = 1'b0;        end
    endcase
    pc_d  = pc_q;
    cnt_d = cnt_q;
    if (done) begin
      pc_d  = uc.nxt;
      cnt_d = '0;
    end else if (step) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PcIdle;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctrl_o = '{op: uc.op, func: uc.func, k: uc.k, sel: cnt_q[SelW-1:0]};

endmodule

### sv/sbc_sched.sv
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// Holds the received block and expands it through a sixteen-word shift line.
// ----------------------------------------------------------------------------
module sbc_sched (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [sbc_pkg::IdxW-1:0]  wr_idx_i,
  input  logic [sbc_pkg::WordW-1:0] wr_data_i,
  input  sbc_pkg::ctrl_t          ctrl_i,
  output logic [sbc_pkg::WordW-1:0] w_o
);
  import sbc_pkg::*;

  // The received words are kept apart, as slots not rewritten carry into the
  // next block.
  logic [WordW-1:0] msg_q  [BlockWords];
  logic [WordW-1:0] line_q [BlockWords];
  logic [WordW-1:0] mix;

  assign mix = line_q[13] ^ line_q[8] ^ line_q[2] ^ line_q[0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      msg_q[wr_idx_i] <= wr_data_i;
    end
    if (ctrl_i.op == OP_LOAD) begin
      line_q <= msg_q;
    end else if (ctrl_i.op == OP_ROUND) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        line_q[i] <= line_q[i+1];
      end
      line_q[BlockWords-1] <= {mix[WordW-2:0], mix[WordW-1]};
    end
  end

  assign w_o = line_q[0];

endmodule

### sv/sbc_core.sv
// ----------------------------------------------------------------------------
// SHA-1 round datapath
// Chaining registers, working variables and the round adder.
// ----------------------------------------------------------------------------
module sbc_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     chain_wr_i,
  input  logic [sbc_pkg::SelW-1:0]  chain_idx_i,
  input  logic [sbc_pkg::WordW-1:0] chain_data_i,
  input  sbc_pkg::ctrl_t           ctrl_i,
  input  logic [sbc_pkg::WordW-1:0] w_i,
  output logic [sbc_pkg::WordW-1:0] digest_o
);
  import sbc_pkg::*;

  logic [WordW-1:0] chain_q [ChainWords];
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q;
  logic [WordW-1:0] f, t;

  always_comb begin
    unique case (ctrl_i.func)
      FN_CH:   f = (b_q & c_q) | (~b_q & d_q);
      FN_MAJ:  f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default: f = b_q ^ c_q ^ d_q;
    endcase
    t = {a_q[WordW-6:0], a_q[WordW-1:WordW-5]} + f + e_q + ctrl_i.k + w_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_q[i] <= '0;
      end
    end else if (ctrl_i.op == OP_ADD) begin
      chain_q[0] <= chain_q[0] + a_q;
      chain_q[1] <= chain_q[1] + b_q;
      chain_q[2] <= chain_q[2] + c_q;
      chain_q[3] <= chain_q[3] + d_q;
      chain_q[4] <= chain_q[4] + e_q;
    end else if (chain_wr_i) begin
      chain_q[chain_idx_i] <= chain_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (ctrl_i.op == OP_ROUND) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[WordW-1:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_comb begin
    unique case (ctrl_i.sel)
      3'd0:    digest_o = chain_q[0];
      3'd1:    digest_o = chain_q[1];
      3'd2:    digest_o = chain_q[2];
      3'd3:    digest_o = chain_q[3];
      3'd4:    digest_o = chain_q[4];
      default: digest_o = '0;
    endcase
  end

endmodule

### sv/sha1_block_compress_top.sv
// ----------------------------------------------------------------------------
// SHA-1 block compression, top level
// The sixteenth accepted message request arms start_q; the sequencer then
// steps through load, the eighty rounds, add and emit, and tvalid is high
// in the emit step. The five digest words follow one per cycle while the
// receiver is ready. Requests are taken one per cycle while tready is high.
// The rounds run one round per cycle through the round adder.
// Reset clears the chain, the word count and the sequencer at once.
// ----------------------------------------------------------------------------
module sha1_block_compress_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] data_word, [35:32] word_index, [39:36] zero
  input  logic [39:0] s_axis_tdata_i,
  // [0] req_type
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] digest_word, [34:32] digest_index, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import sbc_pkg::*;

  localparam logic [IdxW-1:0] LastMsg = IdxW'(BlockWords - 1);

  logic [WordW-1:0] data_word;
  logic [IdxW-1:0]  word_index;
  logic             accept;
  logic             msg_wr;
  logic             chain_wr;
  logic [IdxW-1:0]  words_q;
  logic             start_q;
  ctrl_t            ctrl;
  logic [WordW-1:0] w;
  logic [WordW-1:0] digest;

  assign data_word  = s_axis_tdata_i[31:0];
  assign word_index = s_axis_tdata_i[35:32];

  // Requests are taken only while the sequencer waits and no block is due.
  assign s_axis_tready_o = (ctrl.op == OP_NOP) && !start_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign msg_wr          = accept && s_axis_tuser_i;
  // A chaining load with an index past E is dropped.
  assign chain_wr        = accept && !s_axis_tuser_i && (word_index < IdxW'(ChainWords));

  // Every message request counts, whatever its index; the sixteenth arms the
  // compression, which the sequencer picks up on the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      start_q <= 1'b0;
    end else begin
      if (msg_wr) begin
        words_q <= words_q + IdxW'(1);
      end
      if (msg_wr && (words_q == LastMsg)) begin
        start_q <= 1'b1;
      end else if (ctrl.op == OP_LOAD) begin
        start_q <= 1'b0;
      end
    end
  end

  sbc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .out_ready_i (m_axis_tready_i),
    .ctrl_o      (ctrl)
  );

  sbc_sched u_sched (
    .clk_i     (clk_i),
    .wr_en_i   (msg_wr),
    .wr_idx_i  (word_index),
    .wr_data_i (data_word),
    .ctrl_i    (ctrl),
    .w_o       (w)
  );

  sbc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chain_wr_i   (chain_wr),
    .chain_idx_i  (word_index[SelW-1:0]),
    .chain_data_i (data_word),
    .ctrl_i       (ctrl),
    .w_i          (w),
    .digest_o     (digest)
  );

  // The result run is shown straight from the chaining registers, A first.
  assign m_axis_tvalid_o = (ctrl.op == OP_EMIT);
  assign m_axis_tdata_o  = {5'b0, ctrl.sel, digest};
  assign m_axis_tlast_o  = (ctrl.sel == SelW'(ChainWords - 1));

endmodule

### sv/sha1_block_compress_chk.sv
// ----------------------------------------------------------------------------
// SHA-1 block compression checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_block_compress_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // No request is taken while a result run is shown.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready during result run");

  // The run ends after its last word.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> !m_axis_tvalid_o)
    else $error("result run continued past last word");

  // The last flag marks exactly word E.
  a_last_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[34:32] == 3'd4)))
    else $error("last flag does not match word E");

endmodule

bind sha1_block_compress_top sha1_block_compress_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
